### rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define MFLE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("mfle assertion failed");

// next-cycle implication
`define MFLE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("mfle assertion failed");

`endif

### rtl/core/mfle_pkg.sv
`default_nettype none
package mfle_pkg;
    localparam int NUM_BANDS_DEF  = 32;
    localparam int FFT_POINTS_DEF = 256;

    localparam int POWER_W  = 31;
    localparam int WEIGHT_W = 16;
    localparam int SUM_W    = 54;
    localparam int DB_W     = 17;
    localparam int MUL_W    = 32;
    localparam int FRAC_W   = 24;
    localparam int EXP_W    = 6;

    localparam logic signed [DB_W-1:0] DB_ZERO_SUM = -17'sd35449;
    // 20*log10(2)*256 in q16
    localparam logic [MUL_W-1:0] DB_PER_OCTAVE = 32'd101008905;

    typedef logic [MUL_W-1:0]   t_mul_in;
    typedef logic [2*MUL_W-1:0] t_mul_out;
endpackage
`default_nettype wire

### rtl/core/mfle_mul.sv
`default_nettype none
module mfle_mul
    import mfle_pkg::*;
(
    input  wire logic     i_clk,
    input  wire t_mul_in  i_a,
    input  wire t_mul_in  i_b,
    output t_mul_out      o_p
);
    t_mul_out r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;
endmodule
`default_nettype wire

### rtl/core/mel_filterbank_log_energy_unit.sv
`default_nettype none
// Mel filterbank log energy. A word with i_action low loads one Q1.15 weight;
// a word with i_action high is the next power bin and keeps busy high while it
// does one multiply-accumulate per filter through the single shared
// 32x32 multiplier. After the last bin of a frame (FFT_POINTS/2+1 bins) the block
// emits one result per filter in filter order, each strobed by o_valid for one cycle;
// the receiver cannot stall them. Each result is made by leading-one shifting,
// squaring on the same multiplier for the log2 fraction, then scaling and rounding
// (a zero sum skips these steps). busy stays high until the last result of the
// frame is out. The weight memory is not cleared by reset.
`include "assert_macros.svh"
module mel_filterbank_log_energy_unit
    import mfle_pkg::*;
#(
    parameter int NUM_BANDS  = NUM_BANDS_DEF,
    parameter int FFT_POINTS = FFT_POINTS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic                   i_action,
    input  wire logic [4:0]             i_filter_index,
    input  wire logic [7:0]             i_bin_index,
    input  wire logic [WEIGHT_W-1:0]    i_weight,
    input  wire logic [POWER_W-1:0]     i_power,
    output logic                        o_valid,
    output logic [4:0]                  o_filter_number,
    output logic signed [DB_W-1:0]      o_energy_db,
    output logic                        o_last_filter
);
    localparam int BINS   = FFT_POINTS / 2 + 1;
    localparam int BIN_AW = $clog2(BINS);
    localparam int FAW    = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
    localparam int MEM_D  = 2 ** (FAW + BIN_AW);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MAC  = 4'd1;
    localparam logic [3:0] S_LOAD = 4'd2;
    localparam logic [3:0] S_NORM = 4'd3;
    localparam logic [3:0] S_SQ   = 4'd4;
    localparam logic [3:0] S_SQW  = 4'd5;
    localparam logic [3:0] S_DB   = 4'd6;
    localparam logic [3:0] S_RND  = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    localparam logic [FAW-1:0]    LAST_F   = FAW'(NUM_BANDS - 1);
    localparam logic [BIN_AW-1:0] LAST_BIN = BIN_AW'(BINS - 1);

    logic [3:0]            r_state;
    logic [WEIGHT_W-1:0]   r_wmem [0:MEM_D-1];
    logic [WEIGHT_W-1:0]   r_rd;
    logic [SUM_W-1:0]      r_sum [0:NUM_BANDS-1];
    logic [BIN_AW-1:0]     r_bin;
    logic [POWER_W-1:0]    r_power;
    logic                  r_issuing;
    logic [FAW-1:0]        r_fi;
    logic                  r_v1, r_v2;
    logic [FAW-1:0]        r_f1, r_f2;
    logic [FAW-1:0]        r_lf;
    logic [SUM_W-1:0]      r_norm;
    logic [EXP_W-1:0]      r_e;
    logic [MUL_W-1:0]      r_m;
    logic [FRAC_W-1:0]     r_frac;
    logic [4:0]            r_it;
    logic                  r_neg;
    logic signed [DB_W-1:0] r_db;
    logic                  r_ov;
    logic [4:0]            r_onum;
    logic signed [DB_W-1:0] r_odb;
    logic                  r_olast;

    t_mul_in               mul_a, mul_b;
    t_mul_out              mul_p;
    logic                  acc_ld, acc_bin;
    logic                  ld_ok;
    logic [FAW+BIN_AW-1:0] wr_addr, rd_addr;
    logic [SUM_W:0]        mac_s;
    logic [SUM_W-1:0]      lf_sum;
    logic [32:0]           sq_t;
    logic signed [31:0]    l_s;
    logic [31:0]           l_mag;
    logic [2*MUL_W-1:0]    rnd_a;
    logic [DB_W-1:0]       rnd_mag;

    mfle_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    assign busy    = (r_state != S_IDLE);
    assign acc_ld  = start && !busy && !i_action;
    assign acc_bin = start && !busy && i_action;
    assign ld_ok   = (32'(i_filter_index) < NUM_BANDS) && (32'(i_bin_index) < BINS);
    assign wr_addr = {FAW'(i_filter_index), BIN_AW'(i_bin_index)};
    assign rd_addr = {r_fi, r_bin};
    assign mac_s   = {1'b0, r_sum[r_f2]} + {1'b0, mul_p[SUM_W-1:0]};
    assign lf_sum  = r_sum[r_lf];
    assign sq_t    = mul_p[63:31];
    assign l_s     = $signed({2'b00, r_e, r_frac}) - 32'sd251658240;
    assign l_mag   = l_s[31] ? 32'(-l_s) : 32'(l_s);
    assign rnd_a   = mul_p + (64'd1 << 39);
    assign rnd_mag = rnd_a[56:40];

    always_comb begin
        unique case (r_state)
            S_SQ: begin
                mul_a = r_m;
                mul_b = r_m;
            end
            S_DB: begin
                mul_a = l_mag;
                mul_b = DB_PER_OCTAVE;
            end
            default: begin
                mul_a = {1'b0, r_power};
                mul_b = {16'b0, r_rd};
            end
        endcase
    end

    // weight memory
    always_ff @(posedge i_clk) begin
        if (acc_ld && ld_ok) begin
            r_wmem[wr_addr] <= i_weight;
        end
        r_rd <= r_wmem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_bin     <= '0;
            r_issuing <= 1'b0;
            r_fi      <= '0;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_lf      <= '0;
            r_ov      <= 1'b0;
            for (int i = 0; i < NUM_BANDS; i++) begin
                r_sum[i] <= '0;
            end
        end else begin
            r_ov <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (acc_bin) begin
                        r_power   <= i_power;
                        r_issuing <= 1'b1;
                        r_fi      <= '0;
                        r_state   <= S_MAC;
                    end
                end
                S_MAC: begin
                    r_v1 <= r_issuing;
                    r_f1 <= r_fi;
                    r_v2 <= r_v1;
                    r_f2 <= r_f1;
                    if (r_issuing) begin
                        if (r_fi == LAST_F) begin
                            r_issuing <= 1'b0;
                        end else begin
                            r_fi <= r_fi + 1'b1;
                        end
                    end
                    if (r_v2) begin
                        r_sum[r_f2] <= mac_s[SUM_W] ? {SUM_W{1'b1}} : mac_s[SUM_W-1:0];
                    end
                    if (!r_issuing && !r_v1 && !r_v2) begin
                        if (r_bin == LAST_BIN) begin
                            r_bin   <= '0;
                            r_lf    <= '0;
                            r_state <= S_LOAD;
                        end else begin
                            r_bin   <= r_bin + 1'b1;
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_LOAD: begin
                    if (lf_sum == '0) begin
                        r_db    <= DB_ZERO_SUM;
                        r_state <= S_OUT;
                    end else begin
                        r_norm  <= lf_sum;
                        r_e     <= EXP_W'(SUM_W - 1);
                        r_state <= S_NORM;
                    end
                end
                S_NORM: begin
                    if (r_norm[SUM_W-1]) begin
                        r_m     <= r_norm[SUM_W-1 -: MUL_W];
                        r_frac  <= '0;
                        r_it    <= '0;
                        r_state <= S_SQ;
                    end else begin
                        r_norm <= {r_norm[SUM_W-2:0], 1'b0};
                        r_e    <= r_e - 1'b1;
                    end
                end
                S_SQ: begin
                    r_state <= S_SQW;
                end
                S_SQW: begin
                    r_frac <= {r_frac[FRAC_W-2:0], sq_t[32]};
                    r_m    <= sq_t[32] ? sq_t[32:1] : sq_t[31:0];
                    r_it   <= r_it + 1'b1;
                    r_state <= (r_it == 5'(FRAC_W - 1)) ? S_DB : S_SQ;
                end
                S_DB: begin
                    r_neg   <= l_s[31];
                    r_state <= S_RND;
                end
                S_RND: begin
                    r_db    <= r_neg ? -$signed(rnd_mag) : $signed(rnd_mag);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_ov        <= 1'b1;
                    r_onum      <= 5'(r_lf);
                    r_odb       <= r_db;
                    r_olast     <= (r_lf == LAST_F);
                    r_sum[r_lf] <= '0;
                    if (r_lf == LAST_F) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_lf    <= r_lf + 1'b1;
                        r_state <= S_LOAD;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid         = r_ov;
    assign o_filter_number = r_onum;
    assign o_energy_db     = r_odb;
    assign o_last_filter   = r_olast;

    `MFLE_ASSERT_IMP(a_mid_frame_busy, i_clk, i_rst_n, o_valid && !o_last_filter, busy)
    `MFLE_ASSERT_NXT(a_bin_takes_busy, i_clk, i_rst_n, acc_bin, busy)
    `MFLE_ASSERT_IMP(a_mac_only, i_clk, i_rst_n, r_v2, r_state == S_MAC)
endmodule
`default_nettype wire
